// ===== rtl/spf_pkg.sv =====
`timescale 1ns / 1ps

package spf_pkg;

   // iterative unit depths
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 49;
   localparam int MUL_STAGES = 4;

   // pipeline stage numbers, counted from the input register
   localparam int ST_ABS     = 1;
   localparam int ST_SQ      = 2;
   localparam int ST_DIST2   = 3;
   localparam int ST_CMP     = 4;
   localparam int ST_QUART   = 5;
   localparam int ST_DIFF    = 6;
   localparam int ST_ROOT    = ST_DIST2 + SQRT_STEPS;
   localparam int ST_DIV_IN  = ST_ROOT + 1;
   localparam int ST_HR2     = ST_DIV_IN + 1;
   localparam int ST_DIV_OUT = ST_DIV_IN + DIV_STEPS;
   localparam int ST_L0      = ST_DIV_OUT - MUL_STAGES;
   localparam int ST_L1      = ST_DIV_OUT;
   localparam int ST_L2      = ST_L1 + MUL_STAGES;
   localparam int ST_L3      = ST_L2 + MUL_STAGES;
   localparam int ST_MUL_OUT = ST_L3 + MUL_STAGES;
   localparam int ST_SUM     = ST_MUL_OUT + 1;
   localparam int ST_OUT     = ST_SUM + 1;

   typedef enum logic [2:0] {
      CSR_RADIUS    = 3'd0,
      CSR_REST      = 3'd1,
      CSR_PRESSURE  = 3'd2,
      CSR_VISCOSITY = 3'd3,
      CSR_GRAD      = 3'd4,
      CSR_LAP       = 3'd5
   } csr_index_type;

   typedef logic signed [63:0] q32_type;

   function automatic logic [31:0] mag32(logic signed [31:0] x);
      return x[31] ? 32'(-x) : 32'(x);
   endfunction

   function automatic logic [63:0] mag64(logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   // saturating add to +-(2^63-1)
   function automatic q32_type sat_add(q32_type a, q32_type b);
      logic signed [64:0] s;
      q32_type res;
      s = {a[63], a} + {b[63], b};
      if (!s[64] && s[63]) begin
         res = 64'h7FFF_FFFF_FFFF_FFFF;
      end else if (s[64] && (!s[63] || s[62:0] == 63'd0)) begin
         res = 64'h8000_0000_0000_0001;
      end else begin
         res = s[63:0];
      end
      return res;
   endfunction

   // q32.32 to q16.16, rounded half away from zero, saturated
   function automatic logic [31:0] to_q16(q32_type x);
      logic [63:0] mag;
      logic [47:0] q;
      logic [31:0] res;
      mag = mag64(x);
      q   = 48'((mag + 64'h8000) >> 16);
      if (x[63]) begin
         if (q > 48'h0000_8000_0000) q = 48'h0000_8000_0000;
         res = 32'(~q + 48'd1);
      end else if (q > 48'h0000_7FFF_FFFF) begin
         res = 32'h7FFF_FFFF;
      end else begin
         res = q[31:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/spf_mulsh.sv =====
`timescale 1ns / 1ps

module spf_mulsh (
   input  logic            clock,
   input  logic            en,
   input  logic            shift32,
   input  spf_pkg::q32_type op_a,
   input  spf_pkg::q32_type op_b,
   output spf_pkg::q32_type prod
);
   import spf_pkg::*;

   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [63:0] ma_ff, mb_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] sum_ff;
   logic [127:0] rnd;
   logic [127:0] shifted;
   logic [63:0]  mag_in;
   q32_type      prod_ff;
   q32_type      prod_in;

   assign rnd     = shift32 ? 128'h8000_0000 : 128'h8000;
   assign shifted = shift32 ? (sum_ff >> 32) : (sum_ff >> 16);

   always_comb begin
      mag_in  = (|shifted[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : shifted[63:0];
      prod_in = neg3_ff ? q32_type'(-mag_in) : q32_type'(mag_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // magnitudes and sign
         ma_ff   <= mag64(op_a);
         mb_ff   <= mag64(op_b);
         neg1_ff <= op_a[63] ^ op_b[63];
         // 32x32 partial products
         p00_ff  <= ma_ff[31:0]  * mb_ff[31:0];
         p01_ff  <= ma_ff[31:0]  * mb_ff[63:32];
         p10_ff  <= ma_ff[63:32] * mb_ff[31:0];
         p11_ff  <= ma_ff[63:32] * mb_ff[63:32];
         neg2_ff <= neg1_ff;
         // full product plus rounding constant
         sum_ff  <= {64'd0, p00_ff} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0}
                  + {p11_ff, 64'd0} + rnd;
         neg3_ff <= neg2_ff;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/spf_sqrt.sv =====
`timescale 1ns / 1ps

module spf_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import spf_pkg::*;

   logic [33:0] rem_ff  [SQRT_STEPS];
   logic [31:0] root_ff [SQRT_STEPS];
   logic [63:0] rad_ff  [SQRT_STEPS];
   logic [33:0] rem_in  [SQRT_STEPS];
   logic [31:0] root_in [SQRT_STEPS];
   logic [63:0] rad_in  [SQRT_STEPS];

   // one root bit per stage
   always_comb begin
      logic [33:0] cur_rem;
      logic [31:0] cur_root;
      logic [63:0] cur_rad;
      logic [33:0] rem_t;
      logic [33:0] trial;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (k == 0) begin
            cur_rem  = '0;
            cur_root = '0;
            cur_rad  = radicand;
         end else begin
            cur_rem  = rem_ff[k-1];
            cur_root = root_ff[k-1];
            cur_rad  = rad_ff[k-1];
         end
         rem_t = {cur_rem[31:0], cur_rad[63:62]};
         trial = {cur_root, 2'b01};
         if (rem_t >= trial) begin
            rem_in[k]  = rem_t - trial;
            root_in[k] = {cur_root[30:0], 1'b1};
         end else begin
            rem_in[k]  = rem_t;
            root_in[k] = {cur_root[30:0], 1'b0};
         end
         rad_in[k] = {cur_rad[61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign root = root_ff[SQRT_STEPS-1];

endmodule

// ===== rtl/spf_div.sv =====
`timescale 1ns / 1ps

module spf_div (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] num,
   input  logic [30:0] den,
   output logic [48:0] quo
);
   import spf_pkg::*;

   logic [30:0] rem_ff [DIV_STEPS];
   logic [48:0] low_ff [DIV_STEPS];
   logic [30:0] den_ff [DIV_STEPS];
   logic [48:0] quo_ff [DIV_STEPS];
   logic [30:0] rem_in [DIV_STEPS];
   logic [48:0] low_in [DIV_STEPS];
   logic [30:0] den_in [DIV_STEPS];
   logic [48:0] quo_in [DIV_STEPS];

   // restoring division, one quotient bit per stage
   always_comb begin
      logic [30:0] cur_rem;
      logic [48:0] cur_low;
      logic [30:0] cur_den;
      logic [48:0] cur_quo;
      logic [31:0] rem_t;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k == 0) begin
            cur_rem = {16'd0, num[63:49]};
            cur_low = num[48:0];
            cur_den = den;
            cur_quo = '0;
         end else begin
            cur_rem = rem_ff[k-1];
            cur_low = low_ff[k-1];
            cur_den = den_ff[k-1];
            cur_quo = quo_ff[k-1];
         end
         rem_t = {cur_rem, cur_low[48]};
         if (rem_t >= {1'b0, cur_den}) begin
            rem_in[k] = 31'(rem_t - {1'b0, cur_den});
            quo_in[k] = {cur_quo[47:0], 1'b1};
         end else begin
            rem_in[k] = rem_t[30:0];
            quo_in[k] = {cur_quo[47:0], 1'b0};
         end
         low_in[k] = {cur_low[47:0], 1'b0};
         den_in[k] = cur_den;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

// ===== rtl/sph_pair_force_core.sv =====
`timescale 1ns / 1ps

// SPH pair force engine: each transaction carries one particle-neighbour pair (position
// offset, velocity difference, both densities, all Q16.16) and yields one result transaction
// with the pressure-plus-viscosity force, the Poly6 colour-field gradient and the colour-field
// Laplacian, Q16.16 saturated. A pair at zero distance or at or beyond the smoothing radius
// gives all zeros. The pipeline takes a new transaction every cycle unless a held result is
// stalled; its depth is set by the 32-stage square root feeding the 49-stage dividers for
// d/r, 1-r/h and 1/density, followed by three chained four-stage multipliers. The whole
// pipeline advances together, so a stalled result holds every stage.
// Write the coefficient registers only while the pipeline is empty.

module sph_pair_force_core (
   input  logic               clock,
   input  logic               reset,
   // pair input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_offset_x,
   input  logic signed [31:0] req_offset_y,
   input  logic signed [31:0] req_offset_z,
   input  logic signed [31:0] req_vel_diff_x,
   input  logic signed [31:0] req_vel_diff_y,
   input  logic signed [31:0] req_vel_diff_z,
   input  logic [30:0]        req_own_density,
   input  logic [30:0]        req_neighbour_density,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   output logic signed [31:0] rsp_color_grad_x,
   output logic signed [31:0] rsp_color_grad_y,
   output logic signed [31:0] rsp_color_grad_z,
   output logic signed [31:0] rsp_color_lap,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import spf_pkg::*;

   // ---------------------------------------------------------------- registers
   logic [30:0]        h_ff;
   logic [30:0]        rest_ff;
   logic signed [31:0] pc_ff;
   logic signed [31:0] vc_ff;
   logic signed [31:0] gc_ff;
   logic signed [31:0] lc_ff;
   logic [61:0]        h2_ff;
   logic               csr_wr;
   csr_index_type      csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff    <= 31'd65536;
         rest_ff <= 31'd65536;
         pc_ff   <= '0;
         vc_ff   <= '0;
         gc_ff   <= '0;
         lc_ff   <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_RADIUS:    h_ff    <= csr_pwdata[30:0];
            CSR_REST:      rest_ff <= csr_pwdata[30:0];
            CSR_PRESSURE:  pc_ff   <= csr_pwdata;
            CSR_VISCOSITY: vc_ff   <= csr_pwdata;
            CSR_GRAD:      gc_ff   <= csr_pwdata;
            CSR_LAP:       lc_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_RADIUS:    csr_prdata = {1'b0, h_ff};
         CSR_REST:      csr_prdata = {1'b0, rest_ff};
         CSR_PRESSURE:  csr_prdata = pc_ff;
         CSR_VISCOSITY: csr_prdata = vc_ff;
         CSR_GRAD:      csr_prdata = gc_ff;
         CSR_LAP:       csr_prdata = lc_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // h squared, exact q32.32, follows the radius register
   always_ff @(posedge clock) begin
      h2_ff <= h_ff * h_ff;
   end

   // ---------------------------------------------------------------- flow control
   // every stage moves when the output register is free or being taken
   logic            adv;
   logic [ST_OUT:0] vld_ff;

   assign adv       = !vld_ff[ST_OUT] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[ST_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ST_OUT-1:0], req_valid};
      end
   end

   // ---------------------------------------------------------------- front end
   logic signed [31:0] d_ff    [3][0:ST_L3];
   logic signed [31:0] v_ff    [3][0:ST_L3];
   logic [30:0]        own_ff;
   logic [30:0]        nbr_ff;
   logic [31:0]        dabs_ff [3][ST_ABS:ST_ROOT];
   logic [30:0]        nbre_ff [ST_ABS:ST_ROOT];
   logic signed [33:0] dsum_ff;
   logic [63:0]        sq_ff   [3];
   q32_type            s_ff    [ST_SQ:ST_L1];
   logic [63:0]        dist2_ff [ST_DIST2:ST_QUART];
   logic               zero_ff [ST_CMP:ST_SUM];
   logic [63:0]        b_ff    [ST_CMP:ST_L0];
   logic [63:0]        q_ff;
   q32_type            e_ff    [ST_DIFF:ST_L0];
   logic signed [33:0] dsum_in;
   logic signed [65:0] s_in;
   logic [63:0]        sq_in   [3];
   logic [63:0]        dist2_in;
   logic [63:0]        q_in;

   always_comb begin
      // own + neighbour - 2 rest; a zero neighbour density counts as one lsb minus one lsb
      dsum_in  = $signed({3'b000, own_ff}) + $signed({3'b000, nbr_ff})
               - $signed({2'b00, rest_ff, 1'b0});
      s_in     = pc_ff * dsum_ff;
      for (int i = 0; i < 3; i++) sq_in[i] = dabs_ff[i][ST_ABS] * dabs_ff[i][ST_ABS];
      dist2_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
      // 0.75 of (h^2 - r^2), rounded, lands beside the squared distance
      q_in     = 64'(b_ff[ST_CMP] + {b_ff[ST_CMP][62:0], 1'b0} + 64'd2) >> 2;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // input register
         d_ff[0][0] <= req_offset_x;
         d_ff[1][0] <= req_offset_y;
         d_ff[2][0] <= req_offset_z;
         v_ff[0][0] <= req_vel_diff_x;
         v_ff[1][0] <= req_vel_diff_y;
         v_ff[2][0] <= req_vel_diff_z;
         own_ff     <= req_own_density;
         nbr_ff     <= req_neighbour_density;
         for (int i = 0; i < 3; i++) begin
            for (int t = 1; t <= ST_L3; t++) begin
               d_ff[i][t] <= d_ff[i][t-1];
               v_ff[i][t] <= v_ff[i][t-1];
            end
            dabs_ff[i][ST_ABS] <= mag32(d_ff[i][0]);
            for (int t = ST_ABS + 1; t <= ST_ROOT; t++) dabs_ff[i][t] <= dabs_ff[i][t-1];
            sq_ff[i] <= sq_in[i];
         end
         nbre_ff[ST_ABS] <= (nbr_ff == 31'd0) ? 31'd1 : nbr_ff;
         for (int t = ST_ABS + 1; t <= ST_ROOT; t++) nbre_ff[t] <= nbre_ff[t-1];
         dsum_ff <= dsum_in;
         // pressure scalar, exact
         s_ff[ST_SQ] <= s_in[63:0];
         for (int t = ST_SQ + 1; t <= ST_L1; t++) s_ff[t] <= s_ff[t-1];
         // squared distance
         dist2_ff[ST_DIST2] <= dist2_in;
         for (int t = ST_DIST2 + 1; t <= ST_QUART; t++) dist2_ff[t] <= dist2_ff[t-1];
         // out of range: zero distance or at or beyond h
         zero_ff[ST_CMP] <= (dist2_ff[ST_DIST2] == 64'd0)
                         || (dist2_ff[ST_DIST2] >= {2'b00, h2_ff});
         for (int t = ST_CMP + 1; t <= ST_SUM; t++) zero_ff[t] <= zero_ff[t-1];
         b_ff[ST_CMP] <= {2'b00, h2_ff} - dist2_ff[ST_DIST2];
         for (int t = ST_CMP + 1; t <= ST_L0; t++) b_ff[t] <= b_ff[t-1];
         q_ff <= q_in;
         e_ff[ST_DIFF] <= dist2_ff[ST_QUART] - q_ff;
         for (int t = ST_DIFF + 1; t <= ST_L0; t++) e_ff[t] <= e_ff[t-1];
      end
   end

   // ---------------------------------------------------------------- distance
   logic [31:0] root;

   spf_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (dist2_ff[ST_DIST2]),
      .root     (root)
   );

   // divider operands: numerators are concatenations since the rounding half fits below
   logic [30:0] hr_ff;
   logic [63:0] nl_ff;
   logic [63:0] nu_ff [3];
   logic [30:0] r_ff;
   logic [63:0] nn_ff;
   logic [30:0] nd_ff;
   logic [61:0] hr2_ff [ST_HR2:ST_L1];
   logic [30:0] hr_in;

   assign hr_in = h_ff - root[30:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         hr_ff <= hr_in;
         nl_ff <= {1'b0, hr_in, 2'b00, h_ff[30:1]};
         for (int i = 0; i < 3; i++) nu_ff[i] <= {dabs_ff[i][ST_ROOT], 1'b0, root[31:1]};
         r_ff  <= root[30:0];
         nn_ff <= {15'd0, 1'b1, 18'd0, nbre_ff[ST_ROOT][30:1]};
         nd_ff <= nbre_ff[ST_ROOT];
         hr2_ff[ST_HR2] <= hr_ff * hr_ff;
         for (int t = ST_HR2 + 1; t <= ST_L1; t++) hr2_ff[t] <= hr2_ff[t-1];
      end
   end

   // ---------------------------------------------------------------- dividers
   logic [48:0] l_q;
   logic [48:0] invn_q;
   logic [48:0] u_q [3];

   // 1 - r/h in q0.32
   spf_div u_div_l (
      .clock (clock), .en (adv), .num (nl_ff), .den (h_ff), .quo (l_q)
   );

   // 1/neighbour density in q17.32
   spf_div u_div_n (
      .clock (clock), .en (adv), .num (nn_ff), .den (nd_ff), .quo (invn_q)
   );

   // unit direction d/r in q1.32, per axis
   for (genvar g = 0; g < 3; g++) begin : g_dir
      spf_div u_div_u (
         .clock (clock), .en (adv), .num (nu_ff[g]), .den (r_ff), .quo (u_q[g])
      );
   end

   // ---------------------------------------------------------------- scalar products
   q32_type bb_p, be_p, k_p, w1_p, gcb_p, lcb_p, w_p, c_p, m_p;
   logic [48:0] invn_ff [ST_L1+1:ST_L2];
   logic [48:0] u_ff    [3][ST_L1+1:ST_L3];
   q32_type     k_ff    [ST_L2+1:ST_L3];
   q32_type     m_ff    [ST_L3+1:ST_MUL_OUT];

   // (h^2-r^2)^2 and (h^2-r^2)*(r^2-0.75(h^2-r^2)), landing with the dividers
   spf_mulsh u_mul_bb (
      .clock (clock), .en (adv), .shift32 (1'b1),
      .op_a (q32_type'(b_ff[ST_L0])), .op_b (q32_type'(b_ff[ST_L0])), .prod (bb_p)
   );
   spf_mulsh u_mul_be (
      .clock (clock), .en (adv), .shift32 (1'b1),
      .op_a (q32_type'(b_ff[ST_L0])), .op_b (e_ff[ST_L0]), .prod (be_p)
   );

   // first level
   spf_mulsh u_mul_k (
      .clock (clock), .en (adv), .shift32 (1'b1),
      .op_a (s_ff[ST_L1]), .op_b (q32_type'({2'b00, hr2_ff[ST_L1]})), .prod (k_p)
   );
   spf_mulsh u_mul_w1 (
      .clock (clock), .en (adv), .shift32 (1'b0),
      .op_a (q32_type'({{32{vc_ff[31]}}, vc_ff})), .op_b (q32_type'({15'd0, l_q})),
      .prod (w1_p)
   );
   spf_mulsh u_mul_gcb (
      .clock (clock), .en (adv), .shift32 (1'b0),
      .op_a (q32_type'({{32{gc_ff[31]}}, gc_ff})), .op_b (bb_p), .prod (gcb_p)
   );
   spf_mulsh u_mul_lcb (
      .clock (clock), .en (adv), .shift32 (1'b0),
      .op_a (q32_type'({{32{lc_ff[31]}}, lc_ff})), .op_b (be_p), .prod (lcb_p)
   );

   // second level: divide by neighbour density
   spf_mulsh u_mul_w (
      .clock (clock), .en (adv), .shift32 (1'b1),
      .op_a (w1_p), .op_b (q32_type'({15'd0, invn_ff[ST_L2]})), .prod (w_p)
   );
   spf_mulsh u_mul_c (
      .clock (clock), .en (adv), .shift32 (1'b1),
      .op_a (gcb_p), .op_b (q32_type'({15'd0, invn_ff[ST_L2]})), .prod (c_p)
   );
   spf_mulsh u_mul_m (
      .clock (clock), .en (adv), .shift32 (1'b1),
      .op_a (lcb_p), .op_b (q32_type'({15'd0, invn_ff[ST_L2]})), .prod (m_p)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         invn_ff[ST_L1+1] <= invn_q;
         for (int t = ST_L1 + 2; t <= ST_L2; t++) invn_ff[t] <= invn_ff[t-1];
         for (int i = 0; i < 3; i++) begin
            u_ff[i][ST_L1+1] <= u_q[i];
            for (int t = ST_L1 + 2; t <= ST_L3; t++) u_ff[i][t] <= u_ff[i][t-1];
         end
         k_ff[ST_L2+1] <= k_p;
         for (int t = ST_L2 + 2; t <= ST_L3; t++) k_ff[t] <= k_ff[t-1];
         m_ff[ST_L3+1] <= m_p;
         for (int t = ST_L3 + 2; t <= ST_MUL_OUT; t++) m_ff[t] <= m_ff[t-1];
      end
   end

   // ---------------------------------------------------------------- per-axis products
   q32_type fp_p [3];
   q32_type fv_p [3];
   q32_type cg_p [3];

   for (genvar g = 0; g < 3; g++) begin : g_axis
      // direction takes the sign of its offset
      q32_type u_s;
      assign u_s = d_ff[g][ST_L3][31] ? -q32_type'({15'd0, u_ff[g][ST_L3]})
                                      : q32_type'({15'd0, u_ff[g][ST_L3]});

      spf_mulsh u_mul_fp (
         .clock (clock), .en (adv), .shift32 (1'b1),
         .op_a (k_ff[ST_L3]), .op_b (u_s), .prod (fp_p[g])
      );
      spf_mulsh u_mul_fv (
         .clock (clock), .en (adv), .shift32 (1'b0),
         .op_a (w_p), .op_b (q32_type'({{32{v_ff[g][ST_L3][31]}}, v_ff[g][ST_L3]})),
         .prod (fv_p[g])
      );
      spf_mulsh u_mul_cg (
         .clock (clock), .en (adv), .shift32 (1'b0),
         .op_a (c_p), .op_b (q32_type'({{32{d_ff[g][ST_L3][31]}}, d_ff[g][ST_L3]})),
         .prod (cg_p[g])
      );
   end

   // ---------------------------------------------------------------- sum and output
   q32_type            f_ff  [3];
   q32_type            cg_ff [3];
   q32_type            m98_ff;
   logic signed [31:0] out_ff [7];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            f_ff[i]  <= sat_add(fp_p[i], fv_p[i]);
            cg_ff[i] <= cg_p[i];
         end
         m98_ff <= m_ff[ST_MUL_OUT];
         // out-of-range pairs come out as zeros
         for (int i = 0; i < 3; i++) begin
            out_ff[i]     <= zero_ff[ST_SUM] ? 32'sd0 : to_q16(f_ff[i]);
            out_ff[3 + i] <= zero_ff[ST_SUM] ? 32'sd0 : to_q16(cg_ff[i]);
         end
         out_ff[6] <= zero_ff[ST_SUM] ? 32'sd0 : to_q16(m98_ff);
      end
   end

   assign rsp_force_x      = out_ff[0];
   assign rsp_force_y      = out_ff[1];
   assign rsp_force_z      = out_ff[2];
   assign rsp_color_grad_x = out_ff[3];
   assign rsp_color_grad_y = out_ff[4];
   assign rsp_color_grad_z = out_ff[5];
   assign rsp_color_lap    = out_ff[6];

   // ---------------------------------------------------------------- assertions
   // an out-of-range pair leaving the sum stage produces an all-zero transaction
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[ST_SUM] && zero_ff[ST_SUM]) |=>
      (rsp_force_x == 32'sd0 && rsp_force_y == 32'sd0 && rsp_force_z == 32'sd0 &&
       rsp_color_grad_x == 32'sd0 && rsp_color_grad_y == 32'sd0 &&
       rsp_color_grad_z == 32'sd0 && rsp_color_lap == 32'sd0))
      else $error("out-of-range pair gave a nonzero result");

   // a held pipeline keeps every transaction in place
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid chain moved while stalled");

   // an accepted transaction enters the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted transaction lost at the input register");

endmodule

// ===== bench/pair_force_checker.sv =====
`timescale 1ns / 1ps

module pair_force_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_offset_x,
   input  logic signed [31:0] req_offset_y,
   input  logic signed [31:0] req_offset_z,
   input  logic signed [31:0] req_vel_diff_x,
   input  logic signed [31:0] req_vel_diff_y,
   input  logic signed [31:0] req_vel_diff_z,
   input  logic [30:0]        req_own_density,
   input  logic [30:0]        req_neighbour_density,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_force_x,
   input  logic signed [31:0] rsp_force_y,
   input  logic signed [31:0] rsp_force_z,
   input  logic signed [31:0] rsp_color_grad_x,
   input  logic signed [31:0] rsp_color_grad_y,
   input  logic signed [31:0] rsp_color_grad_z,
   input  logic signed [31:0] rsp_color_lap,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 fail_count,
   output int                 pending
);
   import spf_pkg::*;

   // order: force x y z, color grad x y z, color lap
   typedef logic [6:0][31:0] pair_forces_type;

   localparam longint QMAX = 64'h7FFF_FFFF_FFFF_FFFF;

   pair_forces_type expected_forces[$];
   logic [63:0]     radius, rest;
   longint          press_c, visc_c, grad_c, lap_c;

   function automatic longint round_mul(longint a, longint b, int sh);
      logic        neg;
      logic [63:0] ua, ub;
      logic [127:0] p;
      neg = (a < 0) != (b < 0);
      ua  = a[63] ? 64'(-a) : 64'(a);
      ub  = b[63] ? 64'(-b) : 64'(b);
      p   = {64'd0, ua} * {64'd0, ub};
      p   = (p + (128'd1 << (sh - 1))) >> sh;
      if (p > 128'(QMAX)) p = 128'(QMAX);
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint clamp_add(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(QMAX)) return QMAX;
      if (s < -65'(QMAX)) return -QMAX;
      return longint'(s);
   endfunction

   function automatic logic [31:0] q32_to_q16(longint x);
      logic [63:0] q;
      q = ((x[63] ? 64'(-x) : 64'(x)) + 64'h8000) >> 16;
      if (x < 0) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return 32'(-q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res, bt;
      res = 0;
      bt  = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt >>= 2;
      end
      return res;
   endfunction

   function automatic pair_forces_type predict_pair(longint d[3], longint v[3],
                                                     logic [30:0] own, logic [30:0] nbr_in);
      pair_forces_type res;
      logic [63:0] dist2, h2, r, hr, nbr, b, q, mag, ua;
      longint      invn, dsum, s, k, l, w, c, e, m, u, fp, fv;
      res   = '0;
      dist2 = 0;
      for (int i = 0; i < 3; i++) begin
         mag   = d[i][63] ? 64'(-d[i]) : 64'(d[i]);
         dist2 = dist2 + mag * mag;
      end
      h2 = radius * radius;
      // zero distance or outside the kernel support
      if (dist2 == 0 || dist2 >= h2) return res;
      r    = floor_sqrt(dist2);
      nbr  = (nbr_in == 0) ? 64'd1 : 64'(nbr_in);
      invn = longint'(((64'd1 << 48) + nbr / 2) / nbr);
      dsum = longint'(own) + longint'(nbr) - 2 * longint'(rest);
      if (nbr_in == 0) dsum = dsum - 1;
      s  = press_c * dsum;
      hr = radius - r;
      k  = round_mul(s, longint'(hr * hr), 32);
      l  = longint'(((hr << 32) + radius / 2) / radius);
      w  = round_mul(round_mul(visc_c, l, 16), invn, 32);
      b  = h2 - dist2;
      c  = round_mul(round_mul(grad_c, round_mul(longint'(b), longint'(b), 32), 16), invn, 32);
      q  = (3 * b + 2) >> 2;
      e  = longint'(dist2) - longint'(q);
      m  = round_mul(round_mul(lap_c, round_mul(longint'(b), e, 32), 16), invn, 32);
      for (int i = 0; i < 3; i++) begin
         mag = d[i][63] ? 64'(-d[i]) : 64'(d[i]);
         ua  = ((mag << 32) + r / 2) / r;
         u   = d[i] < 0 ? -longint'(ua) : longint'(ua);
         fp  = round_mul(k, u, 32);
         fv  = round_mul(w, v[i], 16);
         res[i]     = q32_to_q16(clamp_add(fp, fv));
         res[3 + i] = q32_to_q16(round_mul(c, d[i], 16));
      end
      res[6] = q32_to_q16(m);
      return res;
   endfunction

   string field_names[7] = '{"force_x", "force_y", "force_z", "color_grad_x",
                             "color_grad_y", "color_grad_z", "color_lap"};

   assign pending = expected_forces.size();

   always @(posedge clock) begin
      longint          d[3], v[3];
      pair_forces_type got, want;
      logic            bad;
      if (reset) begin
         radius     <= 64'd65536;
         rest       <= 64'd65536;
         press_c    <= 0;
         visc_c     <= 0;
         grad_c     <= 0;
         lap_c      <= 0;
         fail_count <= 0;
         expected_forces.delete();
      end else begin
         // register writes snooped from the port
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[4:2]))
               CSR_RADIUS:    radius  <= 64'(csr_pwdata[30:0]);
               CSR_REST:      rest    <= 64'(csr_pwdata[30:0]);
               CSR_PRESSURE:  press_c <= longint'($signed(csr_pwdata));
               CSR_VISCOSITY: visc_c  <= longint'($signed(csr_pwdata));
               CSR_GRAD:      grad_c  <= longint'($signed(csr_pwdata));
               CSR_LAP:       lap_c   <= longint'($signed(csr_pwdata));
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            d = '{longint'(req_offset_x), longint'(req_offset_y), longint'(req_offset_z)};
            v = '{longint'(req_vel_diff_x), longint'(req_vel_diff_y),
                  longint'(req_vel_diff_z)};
            expected_forces.push_back(predict_pair(d, v, req_own_density,
                                                   req_neighbour_density));
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_color_lap, rsp_color_grad_z, rsp_color_grad_y, rsp_color_grad_x,
                   rsp_force_z, rsp_force_y, rsp_force_x};
            if (expected_forces.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transaction");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_forces.pop_front();
               bad  = 1'b0;
               for (int i = 0; i < 7; i++) begin
                  if (got[i] !== want[i]) begin
                     bad = 1'b1;
                     if (fail_count < 10)
                        $display("mismatch %s: expected %h actual %h",
                                 field_names[i], want[i], got[i]);
                  end
               end
               if (bad) fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import spf_pkg::*;

   localparam int STALL_LIMIT = 5000;   // cycles with no transaction at all
   localparam int DRAIN       = 150;    // longer than the pipeline is deep

   logic               clock, reset;
   logic               req_valid, req_stall;
   logic signed [31:0] req_offset_x, req_offset_y, req_offset_z;
   logic signed [31:0] req_vel_diff_x, req_vel_diff_y, req_vel_diff_z;
   logic [30:0]        req_own_density, req_neighbour_density;
   logic               rsp_valid, rsp_stall;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic signed [31:0] rsp_color_grad_x, rsp_color_grad_y, rsp_color_grad_z;
   logic signed [31:0] rsp_color_lap;
   logic               csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [4:0]         csr_paddr;
   logic [31:0]        csr_pwdata, csr_prdata;
   int                 fail_count, pending;
   int                 idle_cycles, pair_count;
   logic               busy_stretch;   // no idling on either side while set
   logic [30:0]        cur_radius, cur_rest;

   sph_pair_force_core i_dut (.*);

   pair_force_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls at random, changed on the falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = !busy_stretch && ($urandom_range(0, 99) < 19);
      end
   end

   // watchdog: too long with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one write: setup cycle then access cycle
   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (idx == CSR_RADIUS) cur_radius = value[30:0];
      if (idx == CSR_REST) cur_rest = value[30:0];
   endtask

   task automatic set_coefs(logic [31:0] h, logic [31:0] rho, logic [31:0] pc,
                            logic [31:0] vc, logic [31:0] gc, logic [31:0] lc);
      write_reg(CSR_RADIUS, h);
      write_reg(CSR_REST, rho);
      write_reg(CSR_PRESSURE, pc);
      write_reg(CSR_VISCOSITY, vc);
      write_reg(CSR_GRAD, gc);
      write_reg(CSR_LAP, lc);
   endtask

   // wait out every result plus the pipeline depth before touching registers
   task automatic drain_pipeline();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // present one pair, hold it until accepted; valid drops at random between pairs unless busy_stretch is set
   task automatic send_pair(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                            logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                            logic [30:0] own, logic [30:0] nbr);
      while (!busy_stretch && $urandom_range(0, 99) < 19) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid             = 1'b1;
      req_offset_x          = dx;
      req_offset_y          = dy;
      req_offset_z          = dz;
      req_vel_diff_x        = vx;
      req_vel_diff_y        = vy;
      req_vel_diff_z        = vz;
      req_own_density       = own;
      req_neighbour_density = nbr;
      do @(posedge clock); while (req_stall);
      pair_count++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] near_offset(logic [30:0] h);
      logic [31:0] mag;
      mag = $urandom_range(0, h / 2);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   function automatic logic [30:0] near_density(logic [30:0] rho);
      logic [31:0] lo_b, hi_b;
      lo_b = (rho > 31'd65536) ? 32'(rho - 31'd65536) : 32'd1;
      hi_b = (rho < 31'h7FFE_0000) ? 32'(rho + 31'd65536) : 32'h7FFF_FFFF;
      return 31'($urandom_range(lo_b, hi_b));
   endfunction

   // mostly pairs inside the kernel with random content, some full-range noise
   task automatic random_pairs(int count);
      for (int n = 0; n < count; n++) begin
         busy_stretch = (n >= count / 3) && (n < count / 2);
         if ($urandom_range(0, 99) < 80)
            send_pair(near_offset(cur_radius), near_offset(cur_radius),
                      near_offset(cur_radius), $urandom, $urandom, $urandom,
                      near_density(cur_rest), near_density(cur_rest));
         else
            send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      31'($urandom), 31'($urandom));
      end
      busy_stretch = 1'b0;
      req_valid    = 1'b0;
   endtask

   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SMIN = 32'h8000_0000;

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      {req_offset_x, req_offset_y, req_offset_z} = '0;
      {req_vel_diff_x, req_vel_diff_y, req_vel_diff_z} = '0;
      req_own_density       = '0;
      req_neighbour_density = 31'd1;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      busy_stretch = 1'b0;
      pair_count   = 0;
      cur_radius   = 31'd65536;
      cur_rest     = 31'd65536;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed pairs with moderate coefficients, h = 2.0
      set_coefs(32'h0002_0000, ONE, 32'h0000_4000, 32'h0002_0000, 32'hFFFF_8000, ONE);
      send_pair(0, 0, 0, ONE, ONE, ONE, ONE, ONE);                  // zero distance
      send_pair(32'h0002_0000, 0, 0, ONE, 0, 0, ONE, ONE);          // exactly at h
      send_pair(32'h0001_FFFF, 0, 0, ONE, 0, 0, ONE, ONE);          // just inside h
      send_pair(0, 32'hFFFE_0001, 0, 0, ONE, 0, ONE, ONE);          // just inside, negative
      send_pair(0, 0, 1, 0, 0, ONE, ONE, ONE);                      // one lsb apart
      send_pair(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_pair(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 0, 1);
      send_pair(ONE, ONE, 0, SMAX, SMIN, SMAX, 0, 0);               // zero neighbour density
      send_pair(32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000, SMIN, SMAX, SMIN,
                31'h7FFF_FFFF, 1);                                  // tiny divisor
      send_pair(32'hFFFF_0000, 32'h0000_8000, 0, 32'hFFFF_0000, 0, ONE,
                31'h7FFF_FFFF, 31'h7FFF_FFFF);                      // densest pair
      send_pair(32'h0000_1000, 32'h0000_1000, 32'h0000_1000, 0, 0, 0, 0, ONE);
      send_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, ONE, ONE);
      req_valid = 1'b0;
      random_pairs(140);
      drain_pipeline();

      // largest radius, rest density and coefficients
      set_coefs(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
      send_pair(SMIN, 0, 0, 0, 0, 0, 0, 1);
      send_pair(32'h4000_0000, 32'hC000_0000, 32'h4000_0000, SMAX, SMIN, SMAX,
                31'h7FFF_FFFF, 1);
      req_valid = 1'b0;
      random_pairs(140);
      drain_pipeline();

      // smallest nonzero radius, zero rest density, most negative coefficients
      set_coefs(32'd1, 32'd0, SMIN, SMIN, SMIN, SMIN);
      random_pairs(60);
      drain_pipeline();

      // zero radius: nothing is in range
      set_coefs(32'd0, ONE, ONE, ONE, ONE, ONE);
      random_pairs(40);
      drain_pipeline();

      for (int ph = 0; ph < 4; ph++) begin
         set_coefs(ph[0] ? 32'($urandom_range(1, 32'h7FFF_FFFF))
                         : 32'($urandom_range(1, 32'h0010_0000)),
                   $urandom_range(0, 32'h0010_0000),
                   $urandom, $urandom, $urandom, $urandom);
         random_pairs(130);
         drain_pipeline();
      end

      $display("pairs sent: %0d over eight register settings, radius from zero to maximum",
               pair_count);
      $display("covered zero distance, the kernel edge, zero divisor and saturating sums");
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/spf_pkg.sv
rtl/spf_mulsh.sv
rtl/spf_sqrt.sv
rtl/spf_div.sv
rtl/sph_pair_force_core.sv
bench/pair_force_checker.sv
bench/testbench.sv
